@@ src/sprle_pkg.sv @@
// Shared types and constants for the sprite scanline RLE decoder.
// Used by the register block, the controller, the datapath and the top level.
// No dependencies.
package sprle_pkg;

   // Width of the column and row counters.
   localparam int COORD_BITS = 16;
   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   // Comparisons run one bit wider than any coordinate or register value.
   localparam int CMP_BITS = 17;

   localparam int CSR_ADDR_BITS = 4;
   localparam int CSR_DATA_BITS = 32;

   localparam int LIT_BITS = 7;

   typedef enum logic [1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_TRANSPARENT  = 2'd2
   } reg_index_type;

   typedef enum logic [2:0] {
      PH_LEN_LO,
      PH_LEN_HI,
      PH_CODE,
      PH_REPEAT,
      PH_LITERAL
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_STEP,
      ST_PIXEL,
      ST_CLOSE,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic [15:0] frame_width;
      logic [15:0] frame_height;
      logic [7:0]  transparent_index;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_byte;
      logic decode;
      logic emit;
      logic skip;
      logic close;
      logic dummy;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic has_pixels;
      logic line_end_now;
      logic line_end;
      logic pixel_pending;
      logic out_free;
      logic need_dummy;
   } dp_status_type;

endpackage

@@ src/sprite_scanline_rle_decoder.sv @@
// Sprite scanline RLE decoder, top level. Each byte is taken in the idle
// state and decoded in the step state; a byte that ends a scanline adds a
// close step and a frame-end marker an emit step. A repeat or literal byte
// emits its visible pixels while the result side keeps up; the first result
// is registered in the pixel state. Synchronous reset restores the register
// defaults and waits for the first line length. Depends on sprle_pkg.
module sprite_scanline_rle_decoder
   import sprle_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [7:0]               req_data_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic                     rsp_pixel_valid,
   output logic [15:0]              rsp_pixel_x,
   output logic [15:0]              rsp_pixel_y,
   output logic [7:0]               rsp_color_index,
   output logic                     rsp_frame_done,
   output logic                     rsp_last_of_run,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   cfg_type       cfg;
   dp_cmd_type    cmd;
   dp_status_type status;

   sprle_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   sprle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   sprle_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_valid (rsp_pixel_valid),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_color_index (rsp_color_index),
      .rsp_frame_done  (rsp_frame_done),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

@@ src/sprle_csr.sv @@
// Configuration register block: frame width, frame height, transparent index.
// APB-style write and read access. Depends on sprle_pkg.
module sprle_csr
   import sprle_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output cfg_type                  cfg
);

   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type reg_index;
   logic          write_en;

   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[3:2]);
   assign write_en  = psel & penable & pwrite & pready;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_FRAME_WIDTH:  cfg_in.frame_width       = pwdata[15:0];
            REG_FRAME_HEIGHT: cfg_in.frame_height      = pwdata[15:0];
            REG_TRANSPARENT:  cfg_in.transparent_index = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_FRAME_WIDTH:  prdata = {16'd0, cfg_ff.frame_width};
         REG_FRAME_HEIGHT: prdata = {16'd0, cfg_ff.frame_height};
         REG_TRANSPARENT:  prdata = {24'd0, cfg_ff.transparent_index};
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width       <= 16'd0;
         cfg_ff.frame_height      <= 16'd1;
         cfg_ff.transparent_index <= 8'd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ src/sprle_ctrl.sv @@
// Controller state machine of the decoder: sequences byte decode, pixel
// emission, line close and the frame-end marker. Depends on sprle_pkg.
module sprle_ctrl
   import sprle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_STEP;
         end
         ST_STEP: begin
            if (status.has_pixels) state_in = ST_PIXEL;
            else if (status.line_end_now) state_in = ST_CLOSE;
            else state_in = ST_IDLE;
         end
         ST_PIXEL: begin
            // Visible pixels form a prefix of the run; once none is left the
            // rest of the run only moves the column.
            if (!status.pixel_pending) begin
               state_in = status.line_end ? ST_CLOSE : ST_IDLE;
            end
         end
         ST_CLOSE: begin
            state_in = status.need_dummy ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_byte = req_valid;
         end
         ST_STEP: begin
            cmd.decode = 1'b1;
         end
         ST_PIXEL: begin
            cmd.emit = status.pixel_pending & status.out_free;
            cmd.skip = ~status.pixel_pending;
         end
         ST_CLOSE: begin
            cmd.close = 1'b1;
         end
         ST_EMIT: begin
            cmd.dummy = status.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ src/sprle_dpath.sv @@
// Datapath of the decoder: stream phase, line byte count, column, row,
// run counter and the result register. Depends on sprle_pkg.
module sprle_dpath
   import sprle_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   input  logic [7:0]    req_data_byte,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   output logic          rsp_pixel_valid,
   output logic [15:0]   rsp_pixel_x,
   output logic [15:0]   rsp_pixel_y,
   output logic [7:0]    rsp_color_index,
   output logic          rsp_frame_done,
   output logic          rsp_last_of_run
);

   phase_type               phase_ff, phase_in;
   logic [7:0]              len_lo_ff, len_lo_in;
   logic [15:0]             bytes_left_ff, bytes_left_in;
   logic [COORD_BITS-1:0]   column_ff, column_in;
   logic [COORD_BITS-1:0]   row_ff, row_in;
   logic [LIT_BITS-1:0]     literal_ff, literal_in;
   logic [LIT_BITS-1:0]     count_ff, count_in;
   logic [7:0]              byte_ff, byte_in;
   logic                    line_end_ff, line_end_in;
   logic                    any_ff, any_in;

   logic                    out_valid_ff, out_valid_in;
   logic                    out_pixel_ff, out_pixel_in;
   logic [15:0]             out_x_ff, out_x_in;
   logic [15:0]             out_y_ff, out_y_in;
   logic [7:0]              out_color_ff, out_color_in;
   logic                    out_done_ff, out_done_in;
   logic                    out_last_ff, out_last_in;

   logic [15:0]             bytes_dec;
   logic [15:0]             line_len;
   logic [LIT_BITS-1:0]     literal_dec;
   logic [CMP_BITS-1:0]     col_wide;
   logic [CMP_BITS-1:0]     col_next;
   logic [CMP_BITS-1:0]     width_wide;
   logic [CMP_BITS-1:0]     skip_sum;
   logic [CMP_BITS-1:0]     run_sum;
   logic [CMP_BITS-1:0]     height_wide;
   logic [CMP_BITS-1:0]     eff_height;
   logic                    row_last;
   logic                    cur_visible;
   logic                    next_visible;
   logic                    out_free;
   logic                    line_end_now;
   logic                    has_pixels;

   assign bytes_dec   = (bytes_left_ff != 16'd0) ? bytes_left_ff - 16'd1 : 16'd0;
   assign line_len    = {byte_ff, len_lo_ff};
   assign literal_dec = (literal_ff != '0) ? literal_ff - LIT_BITS'(1) : '0;

   assign col_wide   = CMP_BITS'(column_ff);
   assign col_next   = col_wide + CMP_BITS'(1);
   assign width_wide = CMP_BITS'(cfg.frame_width);
   assign skip_sum   = col_wide + CMP_BITS'(byte_ff[7:1]);
   assign run_sum    = col_wide + CMP_BITS'(count_ff);

   // The height in use is clamped to one through the largest coordinate.
   always_comb begin
      height_wide = CMP_BITS'(cfg.frame_height);
      if (height_wide == '0) begin
         eff_height = CMP_BITS'(1);
      end else if (height_wide > CMP_BITS'(COORD_MAX)) begin
         eff_height = CMP_BITS'(COORD_MAX);
      end else begin
         eff_height = height_wide;
      end
   end

   assign row_last = (CMP_BITS'(row_ff) + CMP_BITS'(1)) >= eff_height;

   // The saturated column value counts as outside the frame.
   assign cur_visible = (count_ff != '0) && (col_wide < width_wide)
                        && (column_ff != COORD_MAX)
                        && (byte_ff != cfg.transparent_index);
   assign next_visible = (count_ff > LIT_BITS'(1)) && (col_next < width_wide)
                         && (col_next != CMP_BITS'(COORD_MAX));

   assign out_free = ~out_valid_ff | rsp_ready;

   always_comb begin
      case (phase_ff)
         PH_LEN_HI:  line_end_now = (line_len == 16'd0);
         PH_CODE,
         PH_REPEAT,
         PH_LITERAL: line_end_now = (bytes_dec == 16'd0);
         default:    line_end_now = 1'b0;
      endcase
   end

   assign has_pixels = (phase_ff == PH_REPEAT) || (phase_ff == PH_LITERAL);

   assign status.has_pixels    = has_pixels;
   assign status.line_end_now  = line_end_now;
   assign status.line_end      = line_end_ff;
   assign status.pixel_pending = cur_visible;
   assign status.out_free      = out_free;
   assign status.need_dummy    = row_last & ~any_ff;

   always_comb begin
      phase_in      = phase_ff;
      len_lo_in     = len_lo_ff;
      bytes_left_in = bytes_left_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      literal_in    = literal_ff;
      count_in      = count_ff;
      byte_in       = byte_ff;
      line_end_in   = line_end_ff;
      any_in        = any_ff;

      if (cmd.load_byte) begin
         byte_in = req_data_byte;
         any_in  = 1'b0;
      end

      if (cmd.decode) begin
         line_end_in = line_end_now;
         case (phase_ff)
            PH_LEN_HI: begin
               bytes_left_in = line_len;
               column_in     = '0;
               literal_in    = '0;
               phase_in      = PH_CODE;
            end
            PH_CODE: begin
               bytes_left_in = bytes_dec;
               if (byte_ff[0]) begin
                  if (skip_sum > CMP_BITS'(COORD_MAX)) column_in = COORD_MAX;
                  else column_in = skip_sum[COORD_BITS-1:0];
               end else begin
                  literal_in = LIT_BITS'(byte_ff[7:2]) + LIT_BITS'(1);
                  phase_in   = byte_ff[1] ? PH_REPEAT : PH_LITERAL;
               end
            end
            PH_REPEAT: begin
               bytes_left_in = bytes_dec;
               count_in      = literal_ff;
               literal_in    = '0;
               phase_in      = PH_CODE;
            end
            PH_LITERAL: begin
               bytes_left_in = bytes_dec;
               count_in      = LIT_BITS'(1);
               literal_in    = literal_dec;
               phase_in      = (literal_dec == '0) ? PH_CODE : PH_LITERAL;
            end
            default: begin
               len_lo_in = byte_ff;
               phase_in  = PH_LEN_HI;
            end
         endcase
      end

      if (cmd.emit) begin
         column_in = column_ff + COORD_BITS'(1);
         count_in  = count_ff - LIT_BITS'(1);
         any_in    = 1'b1;
      end

      // The rest of the run lands outside the frame or is transparent.
      if (cmd.skip) begin
         if (run_sum > CMP_BITS'(COORD_MAX)) column_in = COORD_MAX;
         else column_in = run_sum[COORD_BITS-1:0];
         count_in = '0;
      end

      if (cmd.close) begin
         column_in  = '0;
         literal_in = '0;
         phase_in   = PH_LEN_LO;
         row_in     = row_last ? '0 : row_ff + COORD_BITS'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_pixel_in = out_pixel_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_done_in  = out_done_ff;
      out_last_in  = out_last_ff;
      if (cmd.emit) begin
         out_valid_in = 1'b1;
         out_pixel_in = 1'b1;
         out_x_in     = 16'(column_ff);
         out_y_in     = 16'(row_ff);
         out_color_in = byte_ff;
         out_last_in  = ~next_visible;
         out_done_in  = ~next_visible & line_end_ff & row_last;
      end else if (cmd.dummy) begin
         out_valid_in = 1'b1;
         out_pixel_in = 1'b0;
         out_x_in     = 16'd0;
         out_y_in     = 16'd0;
         out_color_in = 8'd0;
         out_last_in  = 1'b1;
         out_done_in  = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_LEN_LO;
         len_lo_ff     <= 8'd0;
         bytes_left_ff <= 16'd0;
         column_ff     <= '0;
         row_ff        <= '0;
         literal_ff    <= '0;
         count_ff      <= '0;
         line_end_ff   <= 1'b0;
         any_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         phase_ff      <= phase_in;
         len_lo_ff     <= len_lo_in;
         bytes_left_ff <= bytes_left_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         literal_ff    <= literal_in;
         count_ff      <= count_in;
         line_end_ff   <= line_end_in;
         any_ff        <= any_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff      <= byte_in;
      out_pixel_ff <= out_pixel_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_done_ff  <= out_done_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_valid = out_pixel_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_color_index = out_color_ff;
   assign rsp_frame_done  = out_done_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule
